>>> hw/rtl/uaset_pkg.sv
package uaset_pkg;

   // Default table size and fixed field widths
   localparam int DEF_CAPACITY = 64;
   localparam int KEY_W        = 64;
   localparam int OP_W         = 2;
   localparam int POS_W        = 6;
   localparam int OUTC_W       = 2;
   localparam int CNT_OUT_W    = 7;

   // Operation codes; the unused code acts as a lookup
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Outcome codes
   localparam logic [OUTC_W-1:0] OUT_NONE = 2'd0;
   localparam logic [OUTC_W-1:0] OUT_DONE = 2'd1;
   localparam logic [OUTC_W-1:0] OUT_FULL = 2'd2;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_APPLY  = 5'b00100,
      ST_MOVE   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   // One finished result item
   typedef struct packed {
      logic                 found;
      logic [POS_W-1:0]     position;
      logic [OUTC_W-1:0]    outcome;
      logic [CNT_OUT_W-1:0] count;
   } rsp_type;

endpackage

>>> hw/rtl/unsorted_array_set_core.sv
// An accepted item passes through search, apply and finish (and move, for a remove that
// hits) before its result is loaded, and may wait behind a stalled earlier result.
// A new item is taken only once the sequencer is idle again; the search reads one stored
// key per cycle through the single table read port, so up to CAPACITY compares.
// Reset clears the key count and sequencer; table contents are left undefined
// and need no clearing pass, since only entries below the count are read.
module unsorted_array_set_core #(
   parameter int CAPACITY = uaset_pkg::DEF_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [uaset_pkg::OP_W-1:0]         req_operation,
   input  logic signed [uaset_pkg::KEY_W-1:0] req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [uaset_pkg::POS_W-1:0]        rsp_position,
   output logic [uaset_pkg::OUTC_W-1:0]       rsp_outcome,
   output logic [uaset_pkg::CNT_OUT_W-1:0]    rsp_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                        seq_idle;
   logic                        seq_done;
   logic                        rsp_free;
   logic                        req_take;
   uaset_pkg::rsp_type          seq_rsp;
   uaset_pkg::rsp_type          rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [uaset_pkg::KEY_W-1:0] wr_data;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic [uaset_pkg::KEY_W-1:0] rd_data;

   assign req_stall = !seq_idle;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   uaset_seq #(.CAPACITY(CAPACITY)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .start_op  (req_operation),
      .start_key (req_key),
      .rsp_free  (rsp_free),
      .idle      (seq_idle),
      .done      (seq_done),
      .result    (seq_rsp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   uaset_store #(.CAPACITY(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Hold the result item until taken, load a new one when the slot frees
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (seq_done) begin
         rsp_in       = seq_rsp;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_ff.found;
   assign rsp_position = rsp_ff.position;
   assign rsp_outcome  = rsp_ff.outcome;
   assign rsp_count    = rsp_ff.count;

endmodule

>>> hw/rtl/uaset_store.sv
module uaset_store #(
   parameter int CAPACITY = uaset_pkg::DEF_CAPACITY,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [uaset_pkg::KEY_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [uaset_pkg::KEY_W-1:0] rd_data
);

   logic [uaset_pkg::KEY_W-1:0] mem_ff [CAPACITY];
   logic [uaset_pkg::KEY_W-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/uaset_seq.sv
module uaset_seq #(
   parameter int CAPACITY = uaset_pkg::DEF_CAPACITY,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [uaset_pkg::OP_W-1:0]  start_op,
   input  logic [uaset_pkg::KEY_W-1:0] start_key,
   input  logic                        rsp_free,
   output logic                        idle,
   output logic                        done,
   output uaset_pkg::rsp_type          result,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_addr,
   output logic [uaset_pkg::KEY_W-1:0] wr_data,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_addr,
   input  logic [uaset_pkg::KEY_W-1:0] rd_data
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   uaset_pkg::state_type st_ff, st_in;
   logic [CNT_W-1:0]               occ_ff, occ_in;
   logic [CNT_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   logic                           found_ff, found_in;
   logic [uaset_pkg::OUTC_W-1:0]   outc_ff, outc_in;
   logic [uaset_pkg::OP_W-1:0]     op_ff, op_in;
   logic [uaset_pkg::KEY_W-1:0]    key_ff, key_in;
   logic                           hit_now;
   logic [CNT_W-1:0]               last_cnt;
   logic [IDX_W+uaset_pkg::POS_W-1:0]     pos_ext;
   logic [CNT_W+uaset_pkg::CNT_OUT_W-1:0] cnt_ext;

   // Compare the entry read in the previous cycle
   assign hit_now  = cmp_vld_ff && (rd_data == key_ff);
   assign last_cnt = occ_ff - CNT_W'(1);

   // Sequence search, update and result
   always_comb begin
      st_in      = st_ff;
      occ_in     = occ_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      hit_idx_in = hit_idx_ff;
      found_in   = found_ff;
      outc_in    = outc_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      wr_en      = 1'b0;
      wr_addr    = hit_idx_ff;
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = rd_idx_ff[IDX_W-1:0];
      done       = 1'b0;
      case (st_ff)
         uaset_pkg::ST_IDLE: begin
            if (start) begin
               op_in     = start_op;
               key_in    = start_key;
               rd_idx_in = '0;
               found_in  = 1'b0;
               outc_in   = uaset_pkg::OUT_NONE;
               st_in     = uaset_pkg::ST_SEARCH;
            end
         end
         uaset_pkg::ST_SEARCH: begin
            if (hit_now) begin
               found_in   = 1'b1;
               hit_idx_in = cmp_idx_ff;
               st_in      = uaset_pkg::ST_APPLY;
            end else if (rd_idx_ff < occ_ff) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end else begin
               found_in   = 1'b0;
               hit_idx_in = '0;
               st_in      = uaset_pkg::ST_APPLY;
            end
         end
         uaset_pkg::ST_APPLY: begin
            st_in = uaset_pkg::ST_FINISH;
            case (op_ff)
               uaset_pkg::OP_INSERT: begin
                  if (!found_ff) begin
                     if (occ_ff < CAP_CNT) begin
                        wr_en   = 1'b1;
                        wr_addr = occ_ff[IDX_W-1:0];
                        wr_data = key_ff;
                        occ_in  = occ_ff + CNT_W'(1);
                        outc_in = uaset_pkg::OUT_DONE;
                     end else begin
                        outc_in = uaset_pkg::OUT_FULL;
                     end
                  end
               end
               uaset_pkg::OP_REMOVE: begin
                  if (found_ff) begin
                     rd_en   = 1'b1;
                     rd_addr = last_cnt[IDX_W-1:0];
                     st_in   = uaset_pkg::ST_MOVE;
                  end
               end
               default: begin
               end
            endcase
         end
         uaset_pkg::ST_MOVE: begin
            // Move the last key into the freed entry
            wr_en   = 1'b1;
            wr_addr = hit_idx_ff;
            wr_data = rd_data;
            occ_in  = last_cnt;
            outc_in = uaset_pkg::OUT_DONE;
            st_in   = uaset_pkg::ST_FINISH;
         end
         uaset_pkg::ST_FINISH: begin
            if (rsp_free) begin
               done  = 1'b1;
               st_in = uaset_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = uaset_pkg::ST_IDLE;
         end
      endcase
   end

   // Mask position and count to their field widths
   assign pos_ext = {{uaset_pkg::POS_W{1'b0}}, hit_idx_ff};
   assign cnt_ext = {{uaset_pkg::CNT_OUT_W{1'b0}}, occ_ff};

   assign result.found    = found_ff;
   assign result.position = pos_ext[uaset_pkg::POS_W-1:0];
   assign result.outcome  = outc_ff;
   assign result.count    = cnt_ext[uaset_pkg::CNT_OUT_W-1:0];
   assign idle            = (st_ff == uaset_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= uaset_pkg::ST_IDLE;
         occ_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         occ_ff     <= occ_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_idx_ff <= hit_idx_in;
      found_ff   <= found_in;
      outc_ff    <= outc_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
   end

endmodule

>>> hw/rtl/uaset_checker.sv
module uaset_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_found,
   input logic [uaset_pkg::POS_W-1:0]     rsp_position,
   input logic [uaset_pkg::OUTC_W-1:0]    rsp_outcome,
   input logic [uaset_pkg::CNT_OUT_W-1:0] rsp_count
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_position) && $stable(rsp_outcome) && $stable(rsp_count))
      else $error("stalled result item changed");

   // Stay busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again while item in work");

   // Report position zero for a missing key
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("position set for a missing key");

   // Refuse only inserts of absent keys
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == uaset_pkg::OUT_FULL) |-> !rsp_found)
      else $error("full status with key present");

   // Never report the unused outcome code
   a_outc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome == uaset_pkg::OUT_NONE)
         || (rsp_outcome == uaset_pkg::OUT_DONE)
         || (rsp_outcome == uaset_pkg::OUT_FULL))
      else $error("unknown outcome code");

endmodule

bind unsorted_array_set_core uaset_checker u_uaset_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position),
   .rsp_outcome  (rsp_outcome),
   .rsp_count    (rsp_count)
);
